@@ rtl/core/rfbc_pkg.sv @@
// Shared types and constants for the range flip bitmap counter.
// Used by the core, the port checker and the testbench.
`default_nettype none

package rfbc_pkg;

    localparam int ROW_W   = 11;
    localparam int COUNT_W = 11;
    localparam int AREA_W  = 40;

    localparam logic [ROW_W-1:0]  ROWS_RESET = 11'd1024;
    localparam logic [AREA_W-1:0] AREA_MAX   = {AREA_W{1'b1}};

    localparam logic CMD_FLIP = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [ROW_W-1:0] row_low;
        logic [ROW_W-1:0] row_high;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] set_count;
        logic [AREA_W-1:0]  area_total;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/range_flip_bitmap_counter_core.sv @@
// Channel   Direction  Handshake                 Payload
// command   in         start && !busy            i_item   (t_item)
// result    out        o_valid, one cycle        o_result (t_result)
// config    in         i_cfg_wr_en               i_cfg_wr_data (rows in use)
//
// A tick or an empty flip returns its result the cycle after the transfer and
// busy stays low, so such items can follow every cycle.
// A flip walks bitmap words 0 .. L (L = (last row - 1) / WORD_BITS), one RAM
// read-modify-write per cycle with the read of the next word overlapping the
// write of this one; the result comes once the last write-back has landed.
// After reset a clearing pass writes all WORD_COUNT words, busy held high.
// The receiver cannot stall; each result shows for exactly one cycle.
// Depends on rfbc_pkg and rfbc_ram.
`default_nettype none

module range_flip_bitmap_counter_core
    import rfbc_pkg::*;
#(
    parameter int MAX_ROWS  = 1024,
    parameter int WORD_BITS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_item            i_item,
    output logic                  o_valid,
    output t_result               o_result,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [ROW_W-1:0] i_cfg_wr_data
);

    localparam int WORD_COUNT = (MAX_ROWS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int IW         = $clog2(WORD_BITS);
    localparam int CW         = $clog2(MAX_ROWS + 1);
    localparam int BW0        = $clog2(MAX_ROWS + WORD_BITS + 1);
    localparam int RW         = (BW0 > ROW_W) ? BW0 : ROW_W;
    localparam int SW         = CW + IW + 2;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CLEAR = 3'b010,
        S_WALK  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_rows, n_rows;
    logic [CW-1:0]       r_count, n_count;
    logic [AREA_W-1:0]   r_area, n_area;
    logic                r_valid, n_valid;
    logic [RW-1:0]       r_first, n_first;
    logic [RW-1:0]       r_last, n_last;
    logic                r_iss_on, n_iss_on;
    logic [WAW-1:0]      r_iss_w, n_iss_w;
    logic [RW-1:0]       r_iss_base, n_iss_base;
    logic                r_dat_vld, n_dat_vld;
    logic [WAW-1:0]      r_dat_w, n_dat_w;
    logic [RW-1:0]       r_dat_base, n_dat_base;
    logic [WAW-1:0]      r_clr_w, n_clr_w;

    logic [ROW_W-1:0]     lim, lo_c, hi_c;
    logic                 empty, accept;
    logic [RW-1:0]        iss_top, dat_top;
    logic                 iss_skip, iss_end, rd_en;
    logic [IW-1:0]        span_a, span_b;
    logic [WORD_BITS-1:0] mask, rd_word;
    logic [IW:0]          ones_hit, span_len;
    logic [SW-1:0]        count_sum;
    logic [AREA_W:0]      area_sum;
    logic                 ram_we;
    logic [WAW-1:0]       ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;

    rfbc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_iss_w),
        .o_rdata (rd_word)
    );

    // Range clipping
    always_comb begin
        lim    = (32'(r_rows) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : r_rows;
        lo_c   = (i_item.row_low == '0) ? ROW_W'(1) : i_item.row_low;
        hi_c   = (i_item.row_high > lim) ? lim : i_item.row_high;
        empty  = (lim == '0) || (lo_c > hi_c);
        accept = start && (r_state == S_IDLE);
    end

    // Issue side: skip words wholly below the range, stop after the last one
    always_comb begin
        iss_top  = r_iss_base + RW'(WORD_BITS - 1);
        iss_skip = iss_top < r_first;
        iss_end  = iss_top >= r_last;
        rd_en    = r_iss_on && !iss_skip;
    end

    // Data side: mask the returned word, count what flips
    always_comb begin
        dat_top = r_dat_base + RW'(WORD_BITS - 1);
        span_a  = (r_first > r_dat_base) ? IW'(r_first - r_dat_base) : '0;
        span_b  = (r_last < dat_top) ? IW'(r_last - r_dat_base) : IW'(WORD_BITS - 1);
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (IW'(i) >= span_a) && (IW'(i) <= span_b);
        end
        ones_hit  = (IW + 1)'($countones(rd_word & mask));
        span_len  = (IW + 1)'(span_b) - (IW + 1)'(span_a) + (IW + 1)'(1);
        count_sum = SW'(r_count) + SW'(span_len) - (SW'(ones_hit) << 1);
        area_sum  = (AREA_W + 1)'(r_area) + (AREA_W + 1)'(r_count);
    end

    always_comb begin
        ram_we    = (r_state == S_CLEAR) || r_dat_vld;
        ram_waddr = (r_state == S_CLEAR) ? r_clr_w : r_dat_w;
        ram_wdata = (r_state == S_CLEAR) ? '0 : (rd_word ^ mask);
    end

    always_comb begin
        n_state    = r_state;
        n_rows     = i_cfg_wr_en ? i_cfg_wr_data : r_rows;
        n_count    = r_count;
        n_area     = r_area;
        n_valid    = 1'b0;
        n_first    = r_first;
        n_last     = r_last;
        n_iss_on   = r_iss_on;
        n_iss_w    = r_iss_w;
        n_iss_base = r_iss_base;
        n_dat_vld  = 1'b0;
        n_dat_w    = r_dat_w;
        n_dat_base = r_dat_base;
        n_clr_w    = r_clr_w;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.cmd == CMD_TICK) begin
                        n_area  = (area_sum > (AREA_W + 1)'(AREA_MAX)) ?
                                  AREA_MAX : area_sum[AREA_W-1:0];
                        n_valid = 1'b1;
                    end else if (empty) begin
                        n_valid = 1'b1;
                    end else begin
                        n_first    = RW'(lo_c - ROW_W'(1));
                        n_last     = RW'(hi_c - ROW_W'(1));
                        n_iss_on   = 1'b1;
                        n_iss_w    = '0;
                        n_iss_base = '0;
                        n_state    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_iss_on) begin
                    n_iss_w    = r_iss_w + WAW'(1);
                    n_iss_base = r_iss_base + RW'(WORD_BITS);
                    n_dat_vld  = rd_en;
                    n_dat_w    = r_iss_w;
                    n_dat_base = r_iss_base;
                    if (iss_end) begin
                        n_iss_on = 1'b0;
                    end
                end
                if (r_dat_vld) begin
                    n_count = CW'(count_sum);
                end
                // Finish once the last write-back has landed
                if (!r_iss_on && !r_dat_vld) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                n_clr_w = r_clr_w + WAW'(1);
                if (r_clr_w == WAW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_rows    <= ROWS_RESET;
            r_count   <= '0;
            r_area    <= '0;
            r_valid   <= 1'b0;
            r_iss_on  <= 1'b0;
            r_dat_vld <= 1'b0;
            r_clr_w   <= '0;
        end else begin
            r_state   <= n_state;
            r_rows    <= n_rows;
            r_count   <= n_count;
            r_area    <= n_area;
            r_valid   <= n_valid;
            r_iss_on  <= n_iss_on;
            r_dat_vld <= n_dat_vld;
            r_clr_w   <= n_clr_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first    <= n_first;
        r_last     <= n_last;
        r_iss_w    <= n_iss_w;
        r_iss_base <= n_iss_base;
        r_dat_w    <= n_dat_w;
        r_dat_base <= n_dat_base;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_valid;
    assign o_result.set_count  = COUNT_W'(r_count);
    assign o_result.area_total = r_area;

endmodule

`default_nettype wire

@@ rtl/core/rfbc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rfbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rfbc_checker.sv @@
// Port-level checker for the range flip bitmap counter core, bound to it below.
// Depends on rfbc_pkg.
`default_nettype none

module rfbc_checker
    import rfbc_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire t_item   i_item,
    input wire logic    o_valid,
    input wire t_result o_result
);

    // Reset starts the clearing pass with no result out
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_valid)
        else $error("reset did not enter the clearing pass");

    // A transfer yields a result at once or holds the core busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("transfer neither answered nor started work");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // A tick answers next cycle and never lowers the area total
    a_tick_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_TICK) |=>
            (o_valid && o_result.area_total >= $past(o_result.area_total)))
        else $error("tick result missing or area total decreased");

    a_flip_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_FLIP) |=> $stable(o_result.area_total))
        else $error("flip changed the area total");

endmodule

bind range_flip_bitmap_counter_core rfbc_checker u_rfbc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

@@ tb/tb_range_flip_bitmap_counter_core.sv @@
// Testbench for range_flip_bitmap_counter_core: a directed table, then random flip and tick
// transfers, checked against a bit-per-row bitmap predictor. Depends on rfbc_pkg.
`default_nettype none

module tb_range_flip_bitmap_counter_core;
    import rfbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS        = 1024;
    localparam int WORD_BITS       = 64;
    localparam int QUIET_LIMIT     = 3000;
    localparam int ITEMS_PER_PHASE = 229;
    localparam int SCRIPT_LEN      = 29;

    typedef enum logic {STEP_ITEM, STEP_CFG} t_step_kind;

    typedef struct packed {
        t_step_kind       kind;
        logic [ROW_W-1:0] rows_value;
        t_item            item;
        logic             typed;
        t_result          typed_result;
    } t_script_row;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             start         = 1'b0;
    logic             busy;
    t_item            i_item        = '0;
    logic             o_valid;
    t_result          o_result;
    logic             i_cfg_wr_en   = 1'b0;
    logic [ROW_W-1:0] i_cfg_wr_data = '0;

    // Bitmap predictor state
    logic [MAX_ROWS-1:0] row_map   = '0;
    int                  ones_total = 0;
    logic [AREA_W-1:0]   area_acc  = '0;
    logic [ROW_W-1:0]    rows_cfg  = ROWS_RESET;

    t_result awaited_tallies[$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    bit      idle_on        = 1'b1;

    // kind, rows, {cmd, low, high}, typed, {count, area}
    t_script_row script [SCRIPT_LEN] = '{
        {STEP_ITEM, 11'd0,    {CMD_TICK, 11'd0,    11'd0},    1'b1, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1,    11'd1024}, 1'b1, {11'd1024, 40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_TICK, 11'd0,    11'd0},    1'b1, {11'd1024, 40'd1024}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd0,    11'd0},    1'b1, {11'd1024, 40'd1024}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd2047, 11'd2047}, 1'b1, {11'd1024, 40'd1024}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1,    11'd2047}, 1'b1, {11'd0,    40'd1024}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd0,    11'd64},   1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd64,   11'd65},   1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_TICK, 11'd2047, 11'd2047}, 1'b0, {11'd0,    40'd0}},
        {STEP_CFG,  11'd100,  {CMD_FLIP, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1,    11'd1024}, 1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_TICK, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_CFG,  11'd10,   {CMD_FLIP, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1,    11'd2047}, 1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_TICK, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_CFG,  11'd0,    {CMD_FLIP, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1,    11'd1024}, 1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_TICK, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_CFG,  11'd2047, {CMD_FLIP, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1000, 11'd2047}, 1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1024, 11'd1024}, 1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_TICK, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_CFG,  11'd1,    {CMD_FLIP, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1,    11'd1},    1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd2,    11'd2},    1'b0, {11'd0,    40'd0}},
        {STEP_CFG,  11'd1024, {CMD_FLIP, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1,    11'd1024}, 1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_TICK, 11'd0,    11'd0},    1'b0, {11'd0,    40'd0}},
        {STEP_ITEM, 11'd0,    {CMD_FLIP, 11'd1024, 11'd1},    1'b0, {11'd0,    40'd0}}
    };

    range_flip_bitmap_counter_core #(
        .MAX_ROWS  (MAX_ROWS),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_valid       (o_valid),
        .o_result      (o_result),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one item to the bitmap and return the count and area after it.
    function automatic t_result advance_bitmap(input t_item it);
        int      limit;
        int      lo;
        int      hi;
        t_result res;
        limit = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        if (it.cmd == CMD_FLIP) begin
            // Row zero reads as row one; an empty or unreachable range flips nothing.
            lo = (it.row_low == 0) ? 1 : int'(it.row_low);
            hi = (it.row_high > limit) ? limit : int'(it.row_high);
            for (int r = lo; r <= hi; r++) begin
                row_map[r-1] = ~row_map[r-1];
                ones_total += row_map[r-1] ? 1 : -1;
            end
        end else if (area_acc > AREA_MAX - AREA_W'(ones_total)) begin
            area_acc = AREA_MAX;
        end else begin
            area_acc = area_acc + AREA_W'(ones_total);
        end
        res.set_count  = ones_total[COUNT_W-1:0];
        res.area_total = area_acc;
        return res;
    endfunction

    task automatic send_item(input t_item it, input logic typed, input t_result typed_res);
        t_result model_res;
        while (idle_on && $urandom_range(99) < 29) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        model_res = advance_bitmap(it);
        awaited_tallies.push_back(typed ? typed_res : model_res);
    endtask

    // Hold off new commands until every result is back and the core is idle.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_tallies.size() != 0 || busy);
    endtask

    task automatic write_rows_in_use(input logic [ROW_W-1:0] value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        rows_cfg = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_watch
        t_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (awaited_tallies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: count=%0d area=%0d",
                                 o_result.set_count, o_result.area_total);
                end else begin
                    want = awaited_tallies.pop_front();
                    if (o_result.set_count != want.set_count ||
                        o_result.area_total != want.area_total) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: count exp=%0d got=%0d, area exp=%0d got=%0d",
                                     want.set_count, o_result.set_count,
                                     want.area_total, o_result.area_total);
                    end
                end
            end
            if (o_valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int    rows_pick;
        int    span;
        int    sel;
        int    lo;
        t_item it;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == STEP_CFG)
                write_rows_in_use(script[i].rows_value);
            else
                send_item(script[i].item, script[i].typed, script[i].typed_result);
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       rows_pick = MAX_ROWS;
                1:       rows_pick = 1;
                2:       rows_pick = 2047;
                3:       rows_pick = 0;
                5:       rows_pick = 64;
                6:       rows_pick = 65;
                default: rows_pick = $urandom_range(2, MAX_ROWS - 1);
            endcase
            write_rows_in_use(ROW_W'(rows_pick));
            idle_on = (phase != 5);
            span = (rows_pick == 0) ? MAX_ROWS :
                   (rows_pick > MAX_ROWS) ? MAX_ROWS : rows_pick;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == 100)
                    drain_results();
                sel = $urandom_range(99);
                it.cmd = (sel < 30) ? CMD_TICK : CMD_FLIP;
                if (sel < 45) begin
                    // ticks and noise: any field value
                    it.row_low  = ROW_W'($urandom_range(2047));
                    it.row_high = ROW_W'($urandom_range(2047));
                end else begin
                    lo = $urandom_range(1, span);
                    it.row_low  = ROW_W'(lo);
                    it.row_high = ($urandom_range(3) == 0) ? ROW_W'(lo) :
                                  ROW_W'($urandom_range(lo, span));
                end
                send_item(it, 1'b0, '0);
            end
        end

        drain_results();
        repeat (25) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_tallies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/rfbc_pkg.sv
rtl/core/rfbc_ram.sv
rtl/core/range_flip_bitmap_counter_core.sv
rtl/core/rfbc_checker.sv
tb/tb_range_flip_bitmap_counter_core.sv
